// File: hw/rtl/ostb_pkg.sv
`timescale 1ns / 1ps

package ostb_pkg;

  localparam int NUM_TIMERS_DEF = 128;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_ALLOC = 3'd1,
    KIND_START = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_CHECK = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_EXPIRED = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // write-back control for one slot
  typedef struct packed {
    logic    status_we;
    logic    timer_we;
    status_t status;
  } wr_ctl_t;

endpackage

// File: hw/rtl/one_shot_timer_bank_unit.sv
`timescale 1ns / 1ps
// A request is taken while idle; the block then enters its execute state and registers
//   the result strobe from it. No new request is taken while busy; busy is high for
//   the cycle in which the slot memory read returns and the slot is written back.
// The receiver cannot stall; out_valid lasts exactly one cycle per request.
// Reset (synchronous, rst_n low) clears time, allocation pointer, handle base and all
//   slot status to idle at once; no clearing pass is needed.
module one_shot_timer_bank_unit #(
  parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_handle,
  input  logic [30:0] in_duration,
  output logic        out_valid,
  output logic [15:0] out_handle_out,
  output logic [1:0]  out_status,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_handle_base
);

  localparam int SW = $clog2(NUM_TIMERS);

  ostb_pkg::fsm_t    state_r, state_nxt;
  logic [15:0]       base_r;
  logic [31:0]       time_now_r, time_now_nxt;
  logic [7:0]        next_slot_r, next_slot_nxt;

  ostb_pkg::kind_t   kind_r;
  logic              known_r;
  logic [SW-1:0]     slot_r;
  logic [30:0]       dur_r;

  logic              accept;
  logic [15:0]       offset;
  logic [31:0]       elapsed;
  logic [31:0]       rd_start_time;
  logic [30:0]       rd_limit;
  ostb_pkg::status_t rd_status;
  ostb_pkg::wr_ctl_t wr_ctl;
  ostb_pkg::status_t chk_status;

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_handle_r, out_handle_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_error_r, out_error_nxt;

  assign busy      = (state_r == ostb_pkg::FSM_EXEC);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign offset    = in_handle - base_r;

  ostb_store #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_en         (accept),
    .rd_addr       (offset[SW-1:0]),
    .wr_addr       (slot_r),
    .wr_ctl        (wr_ctl),
    .wr_start_time (time_now_r),
    .wr_limit      (dur_r),
    .rd_start_time (rd_start_time),
    .rd_limit      (rd_limit),
    .rd_status     (rd_status)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= ostb_pkg::kind_t'(in_kind);
      known_r <= (offset < 16'(NUM_TIMERS));
      slot_r  <= offset[SW-1:0];
      dur_r   <= in_duration;
    end
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    out_error_r  <= out_error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ostb_pkg::FSM_IDLE;
      base_r      <= '0;
      time_now_r  <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_now_r  <= time_now_nxt;
      next_slot_r <= next_slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_handle_base;
      end
    end
  end

  assign elapsed    = time_now_r - rd_start_time;
  assign chk_status = (rd_status == ostb_pkg::ST_RUNNING && elapsed >= {1'b0, rd_limit})
                      ? ostb_pkg::ST_EXPIRED : rd_status;

  always_comb begin
    state_nxt      = state_r;
    time_now_nxt   = time_now_r;
    next_slot_nxt  = next_slot_r;
    wr_ctl         = '{status_we: 1'b0, timer_we: 1'b0, status: ostb_pkg::ST_IDLE};
    out_valid_nxt  = 1'b0;
    out_handle_nxt = '0;
    out_status_nxt = '0;
    out_error_nxt  = 1'b0;
    case (state_r)
      ostb_pkg::FSM_IDLE: begin
        if (start) begin
          state_nxt = ostb_pkg::FSM_EXEC;
        end
      end
      ostb_pkg::FSM_EXEC: begin
        state_nxt     = ostb_pkg::FSM_IDLE;
        out_valid_nxt = 1'b1;
        case (kind_r)
          ostb_pkg::KIND_TICK: begin
            time_now_nxt = time_now_r + 32'd1;
          end
          ostb_pkg::KIND_ALLOC: begin
            if (next_slot_r < 8'(NUM_TIMERS)) begin
              out_handle_nxt = base_r + {8'd0, next_slot_r};
              next_slot_nxt  = next_slot_r + 8'd1;
            end else begin
              out_error_nxt = 1'b1;
            end
          end
          ostb_pkg::KIND_START: begin
            wr_ctl.status_we = known_r;
            wr_ctl.timer_we  = known_r;
            wr_ctl.status    = ostb_pkg::ST_RUNNING;
          end
          ostb_pkg::KIND_STOP: begin
            wr_ctl.status_we = known_r;
            wr_ctl.status    = ostb_pkg::ST_IDLE;
          end
          ostb_pkg::KIND_CHECK: begin
            wr_ctl.status_we = known_r;
            wr_ctl.status    = chk_status;
            out_status_nxt   = known_r ? chk_status : ostb_pkg::ST_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ostb_pkg::FSM_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;
  assign out_error      = out_error_r;

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ostb_pkg::FSM_EXEC))
    else $error("result strobe without a finished request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= 8'(NUM_TIMERS))
    else $error("allocation pointer past bank size");

  a_error_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_handle_out == 16'd0 && out_status == 2'd0))
    else $error("failed allocate carries a handle or status");

endmodule

// File: hw/rtl/ostb_store.sv
`timescale 1ns / 1ps

module ostb_store #(
  parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(NUM_TIMERS)-1:0] rd_addr,
  input  logic [$clog2(NUM_TIMERS)-1:0] wr_addr,
  input  ostb_pkg::wr_ctl_t             wr_ctl,
  input  logic [31:0]                   wr_start_time,
  input  logic [30:0]                   wr_limit,
  output logic [31:0]                   rd_start_time,
  output logic [30:0]                   rd_limit,
  output ostb_pkg::status_t             rd_status
);

  logic [31:0]       start_mem [NUM_TIMERS];
  logic [30:0]       limit_mem [NUM_TIMERS];
  ostb_pkg::status_t stat_mem  [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] vld_r;
  logic [31:0]           rd_start_r;
  logic [30:0]           rd_limit_r;
  ostb_pkg::status_t     rd_stat_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.timer_we) begin
      start_mem[wr_addr] <= wr_start_time;
      limit_mem[wr_addr] <= wr_limit;
    end
    if (wr_ctl.status_we) begin
      stat_mem[wr_addr] <= wr_ctl.status;
    end
    if (rd_en) begin
      rd_start_r <= start_mem[rd_addr];
      rd_limit_r <= limit_mem[rd_addr];
      rd_stat_r  <= stat_mem[rd_addr];
    end
  end

  // per-slot written flags: unwritten status reads as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ctl.status_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_start_time = rd_start_r;
  assign rd_limit      = rd_limit_r;
  assign rd_status     = rd_vld_r ? rd_stat_r : ostb_pkg::ST_IDLE;

endmodule

// File: tb/tb_one_shot_timer_bank_unit.sv
`timescale 1ns / 1ps

module tb_one_shot_timer_bank_unit;

  localparam int          NT          = ostb_pkg::NUM_TIMERS_DEF;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          PHASE_ITEMS = 310;
  localparam logic [30:0] DUR_MAX     = 31'h7FFF_FFFF;
  localparam logic [2:0]  KIND_RSVD_5 = 3'd5;
  localparam logic [2:0]  KIND_RSVD_6 = 3'd6;
  localparam logic [2:0]  KIND_RSVD_7 = 3'd7;

  typedef struct {
    logic [15:0] handle;
    logic [1:0]  status;
    logic        err;
  } timer_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [30:0] duration;
    bit          known;
    timer_res_t  res;
  } timer_req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = '0;
  logic [15:0] in_handle = '0;
  logic [30:0] in_duration = '0;
  logic        out_valid;
  logic [15:0] out_handle_out;
  logic [1:0]  out_status;
  logic        out_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_handle_base = '0;

  // predictor state
  logic [31:0]       bank_time;
  logic [7:0]        bank_next;
  logic [15:0]       bank_base;
  logic [31:0]       slot_start [NT];
  logic [30:0]       slot_limit [NT];
  ostb_pkg::status_t slot_state [NT];

  timer_res_t     exp_results [$];
  timer_req_row_t directed_rows [$];

  int errors;
  int n_req;
  int n_res;
  int n_full;
  int n_expired;
  int n_bases;
  int idle_cycles;

  always #4 clk = ~clk;

  one_shot_timer_bank_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_handle       (in_handle),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_handle_out  (out_handle_out),
    .out_status      (out_status),
    .out_error       (out_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_handle_base (cfg_handle_base)
  );

  function automatic void predict_request(input logic [2:0] k, input logic [15:0] h,
                                          input logic [30:0] d, output timer_res_t r);
    logic [15:0] off;
    int          s;
    r.handle = '0;
    r.status = ostb_pkg::ST_IDLE;
    r.err    = 1'b0;
    off = h - bank_base;
    s   = off;
    case (k)
      ostb_pkg::KIND_TICK: bank_time = bank_time + 32'd1;
      ostb_pkg::KIND_ALLOC: begin
        if (bank_next < NT) begin
          r.handle  = bank_base + {8'd0, bank_next};
          bank_next = bank_next + 8'd1;
        end else begin
          r.err = 1'b1;
        end
      end
      ostb_pkg::KIND_START: begin
        if (s < NT) begin
          slot_start[s] = bank_time;
          slot_limit[s] = d;
          slot_state[s] = ostb_pkg::ST_RUNNING;
        end
      end
      ostb_pkg::KIND_STOP: begin
        if (s < NT) slot_state[s] = ostb_pkg::ST_IDLE;
      end
      ostb_pkg::KIND_CHECK: begin
        if (s < NT) begin
          if (slot_state[s] == ostb_pkg::ST_RUNNING &&
              (bank_time - slot_start[s]) >= {1'b0, slot_limit[s]})
            slot_state[s] = ostb_pkg::ST_EXPIRED;
          r.status = slot_state[s];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [2:0] k, input logic [15:0] h,
                                  input logic [30:0] d, input bit known,
                                  input logic [15:0] eh, input logic [1:0] es, input bit ee);
    timer_req_row_t row;
    row.kind       = k;
    row.handle     = h;
    row.duration   = d;
    row.known      = known;
    row.res.handle = eh;
    row.res.status = es;
    row.res.err    = ee;
    directed_rows.push_back(row);
  endfunction

  // call just after a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic [2:0] k, input logic [15:0] h, input logic [30:0] d,
                              input bit known, input timer_res_t typed);
    timer_res_t r;
    start       <= 1'b1;
    in_kind     <= k;
    in_handle   <= h;
    in_duration <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(k, h, d, r);
    exp_results.push_back(known ? typed : r);
    n_req++;
  endtask

  task automatic write_base(input logic [15:0] v);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_handle_base <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bank_base = v;
    n_bases++;
  endtask

  task automatic run_random(input int n);
    timer_res_t  none;
    logic [2:0]  k;
    logic [15:0] h;
    logic [30:0] d;
    int          left;
    int          burst;
    int          gap;
    int          pick;
    none = '{default: '0};
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && left > 0; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) k = ostb_pkg::KIND_TICK;
        else if (pick < 33) k = ostb_pkg::KIND_ALLOC;
        else if (pick < 55) k = ostb_pkg::KIND_START;
        else if (pick < 65) k = ostb_pkg::KIND_STOP;
        else if (pick < 95) k = ostb_pkg::KIND_CHECK;
        else k = 3'($urandom_range(KIND_RSVD_5, KIND_RSVD_7));
        if ($urandom_range(0, 99) < 85) h = bank_base + 16'($urandom_range(0, NT - 1));
        else h = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) d = 31'($urandom_range(0, 15));
        else if (pick < 85) d = 31'($urandom_range(0, 200));
        else d = 31'($urandom);
        send_request(k, h, d, 1'b0, none);
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(posedge clk);
    start <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    timer_res_t e;
    if (rst_n && out_valid) begin
      n_res++;
      if (out_error) n_full++;
      if (out_status == ostb_pkg::ST_EXPIRED) n_expired++;
      if (exp_results.size() == 0) begin
        $display("%0t: result with nothing expected: handle %h status %0d error %0d",
                 $time, out_handle_out, out_status, out_error);
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (out_handle_out !== e.handle) begin
          $display("%0t: handle_out expected %h actual %h", $time, e.handle, out_handle_out);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_error !== e.err) begin
          $display("%0t: error expected %0d actual %0d", $time, e.err, out_error);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_one_shot_timer_bank_unit: done, errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] bases [6];
    timer_res_t  typed;
    errors      = 0;
    n_req       = 0;
    n_res       = 0;
    n_full      = 0;
    n_expired   = 0;
    n_bases     = 0;
    idle_cycles = 0;
    bank_time   = '0;
    bank_next   = '0;
    bank_base   = '0;
    for (int i = 0; i < NT; i++) slot_state[i] = ostb_pkg::ST_IDLE;

    //       kind                  handle    duration  known handle status               err
    add_row(ostb_pkg::KIND_CHECK, 16'd0,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_ALLOC, 16'd0,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_ALLOC, 16'd0,    31'd0,    1, 16'd1, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_START, 16'd0,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd0,    31'd0,    1, 16'd0, ostb_pkg::ST_EXPIRED, 0);
    add_row(ostb_pkg::KIND_START, 16'd1,    DUR_MAX,  1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_TICK,  16'hFFFF, DUR_MAX,  1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd1,    31'd0,    1, 16'd0, ostb_pkg::ST_RUNNING, 0);
    add_row(ostb_pkg::KIND_START, 16'd2,    31'd2,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd2,    31'd0,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_TICK,  16'd0,    31'd0,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_TICK,  16'd0,    31'd0,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd2,    31'd0,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_STOP,  16'd2,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd2,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd127,  31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd128,  31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_START, 16'hFFFF, 31'd5,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'hFFFF, 31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_START, 16'd1,    31'd1,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_CHECK, 16'd1,    31'd0,    0, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(KIND_RSVD_5,          16'hFFFF, DUR_MAX,  1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(KIND_RSVD_6,          16'd1,    31'd3,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(KIND_RSVD_7,          16'd0,    31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);
    add_row(ostb_pkg::KIND_STOP,  16'd200,  31'd0,    1, 16'd0, ostb_pkg::ST_IDLE,    0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed = directed_rows[i].res;
      send_request(directed_rows[i].kind, directed_rows[i].handle,
                   directed_rows[i].duration, directed_rows[i].known, typed);
    end
    @(posedge clk);
    start <= 1'b0;

    bases[0] = 16'hFFFF;
    bases[1] = 16'h0000;
    bases[2] = 16'($urandom);
    bases[3] = 16'hFFC0;   // slot window wraps through zero
    bases[4] = 16'h8000;
    bases[5] = 16'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_base(bases[p]);
      run_random(PHASE_ITEMS);
    end

    while (exp_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests, %0d results, %0d handle bases;", n_req, n_res, n_bases + 1);
    $display("%0d expired reports, %0d full-bank allocates", n_expired, n_full);
    if (errors == 0) begin
      $display("tb_one_shot_timer_bank_unit: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_one_shot_timer_bank_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ostb_pkg.sv
hw/rtl/ostb_store.sv
hw/rtl/one_shot_timer_bank_unit.sv
tb/tb_one_shot_timer_bank_unit.sv
